// File: design/rmh_pkg.sv
// ----------------------------------------------------------------------------
// Running median package
// Shared types and constants for the two-heap running median block.
// ----------------------------------------------------------------------------
`default_nettype none
package rmh_pkg;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned MED_W = 33;
  localparam int unsigned CNT_W = 11;

  // Command to a heap engine.
  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_INSERT,
    HOP_REPLACE
  } heap_op_t;

  typedef struct packed {
    heap_op_t          op;
    logic [VAL_W-1:0]  value;
  } heap_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [VAL_W-1:0]  top;
  } heap_stat_t;
endpackage
`default_nettype wire

// File: design/rmh_heap.sv
// ----------------------------------------------------------------------------
// Heap engine
// One RAM-held binary heap with a sequencer that sifts a value up on insert
// or down on top replacement, one compare per read/write step.
// ----------------------------------------------------------------------------
`default_nettype none
module rmh_heap #(
  parameter int unsigned DEPTH = 512,
  parameter bit          IS_MAX = 1'b1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rmh_pkg::heap_cmd_t cmd,
  output rmh_pkg::heap_stat_t   stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import rmh_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_UP_ROOT, S_DN_RDL, S_DN_RDR, S_DN_LAT, S_DN_CMP
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W-1:0]  top;
  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  lval;
  logic [NW:0]       idx;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [VAL_W-1:0]  wdata;
  logic [AW-1:0]     raddr;
  logic [NW:0]       lidx;
  logic [NW:0]       ridx;
  logic [NW:0]       pidx;
  logic [NW:0]       best;
  logic [VAL_W-1:0]  bval;

  function automatic logic above(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    if (IS_MAX) return $signed(a) > $signed(b);
    else        return $signed(a) < $signed(b);
  endfunction

  assign lidx = {idx[NW-1:0], 1'b1};
  assign ridx = lidx + 1'b1;
  assign pidx = (idx - 1'b1) >> 1;

  // Pick the entry that belongs at the hole: the hole value or a child.
  always_comb begin
    best = idx;
    bval = val;
    if (above(lval, bval)) begin
      best = lidx;
      bval = lval;
    end
    if (ridx < (NW+1)'(count) && above(rdata, bval)) begin
      best = ridx;
      bval = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // The value being placed is kept in val; the memory slot at idx is a hole that
  // is only written once the value has found its place.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      we    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          we <= (cmd.op == HOP_INSERT) && (count == '0);
          if (cmd.op == HOP_INSERT) begin
            val   <= cmd.value;
            idx   <= (NW+1)'(count);
            count <= count + 1'b1;
            if (count == '0) begin
              top   <= cmd.value;
              waddr <= '0;
              wdata <= cmd.value;
            end else begin
              raddr <= AW'(((NW+1)'(count) - 1'b1) >> 1);
              state <= S_UP_RD;
            end
          end else if (cmd.op == HOP_REPLACE) begin
            val   <= cmd.value;
            idx   <= '0;
            top   <= cmd.value;
            state <= S_DN_RDL;
          end
        end
        S_UP_RD: begin
          we    <= 1'b0;
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          we    <= 1'b1;
          waddr <= AW'(idx);
          if (above(val, rdata)) begin
            wdata <= rdata;
            idx   <= pidx;
            if (pidx == '0) begin
              state <= S_UP_ROOT;
            end else begin
              raddr <= AW'((pidx - 1'b1) >> 1);
              state <= S_UP_RD;
            end
          end else begin
            wdata <= val;
            state <= S_IDLE;
          end
        end
        S_UP_ROOT: begin
          we    <= 1'b1;
          waddr <= '0;
          wdata <= val;
          top   <= val;
          state <= S_IDLE;
        end
        S_DN_RDL: begin
          we <= (lidx >= (NW+1)'(count));
          if (lidx >= (NW+1)'(count)) begin
            waddr <= AW'(idx);
            wdata <= val;
            state <= S_IDLE;
          end else begin
            raddr <= AW'(lidx);
            state <= S_DN_RDR;
          end
        end
        S_DN_RDR: begin
          we    <= 1'b0;
          raddr <= AW'(ridx);
          state <= S_DN_LAT;
        end
        S_DN_LAT: begin
          we    <= 1'b0;
          lval  <= rdata;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          we    <= 1'b1;
          waddr <= AW'(idx);
          wdata <= bval;
          if (best == idx) begin
            state <= S_IDLE;
          end else begin
            if (idx == '0) top <= bval;
            idx   <= best;
            state <= S_DN_RDL;
          end
        end
      endcase
    end
  end

  always_comb begin
    stat.busy = (state != S_IDLE) || (cmd.op != HOP_NONE);
    stat.top  = top;
  end
endmodule
`default_nettype wire

// File: design/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// Running median over two heaps
// Routes each word into a max-heap or min-heap, rebalances, reports 2x median.
// ----------------------------------------------------------------------------
// The result strobe follows accept once neither heap is busy; the longest wait is the
// sift-down pass through one heap RAM (read left, read right, latch, compare a level).
// Words are taken one at a time; busy is high until the result strobe, so the next
// word is accepted only after the result of the last one.
// Reset: rst clears both counts; heap RAM contents are left as they are.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
module running_median_two_heaps #(
  parameter int unsigned HEAP_DEPTH = 512
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [rmh_pkg::VAL_W-1:0]     sample_value,
  output logic                                      done,
  output logic signed [rmh_pkg::MED_W-1:0]          median_doubled,
  output logic [rmh_pkg::CNT_W-1:0]                 element_count,
  output logic                                      dropped
);
  import rmh_pkg::*;

  localparam int unsigned NW = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_WAIT, S_REPORT} state_t;

  state_t            state;
  heap_cmd_t         lcmd, ucmd;
  heap_cmd_t         lcmd_next, ucmd_next;
  heap_stat_t        lstat, ustat;
  logic [NW-1:0]     lcnt, ucnt;
  logic signed [VAL_W-1:0] x;
  logic              drop;

  rmh_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b1)) u_lower (
    .clk(clk), .rst(rst), .cmd(lcmd), .stat(lstat), .count(lcnt));
  rmh_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b0)) u_upper (
    .clk(clk), .rst(rst), .cmd(ucmd), .stat(ustat), .count(ucnt));

  logic signed [VAL_W-1:0] ltop, utop;
  assign ltop = lstat.top;
  assign utop = ustat.top;

  // Routing and rebalance are issued together so no heap outgrows its RAM.
  always_comb begin
    lcmd_next = '{op: HOP_NONE, value: '0};
    ucmd_next = '{op: HOP_NONE, value: '0};
    if (state == S_LAUNCH && !drop) begin
      if (lcnt == '0 || x <= ltop) begin
        if ({1'b0, lcnt} == {1'b0, ucnt} + 1'b1) begin
          if (x >= ltop) ucmd_next = '{op: HOP_INSERT, value: x};
          else begin
            ucmd_next = '{op: HOP_INSERT, value: ltop};
            lcmd_next = '{op: HOP_REPLACE, value: x};
          end
        end else lcmd_next = '{op: HOP_INSERT, value: x};
      end else if (ucnt == lcnt) begin
        if (ucnt == '0 || x <= utop) lcmd_next = '{op: HOP_INSERT, value: x};
        else begin
          lcmd_next = '{op: HOP_INSERT, value: utop};
          ucmd_next = '{op: HOP_REPLACE, value: x};
        end
      end else ucmd_next = '{op: HOP_INSERT, value: x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      lcmd  <= '{op: HOP_NONE, value: '0};
      ucmd  <= '{op: HOP_NONE, value: '0};
    end else begin
      lcmd <= lcmd_next;
      ucmd <= ucmd_next;
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            x     <= sample_value;
            drop  <= (lcnt == NW'(HEAP_DEPTH)) && (ucnt == NW'(HEAP_DEPTH));
            busy  <= 1'b1;
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          done  <= 1'b0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          done <= 1'b0;
          if (!lstat.busy && !ustat.busy) state <= S_REPORT;
        end
        S_REPORT: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          dropped <= drop;
          element_count <= CNT_W'(lcnt) + CNT_W'(ucnt);
          if (lcnt == '0) median_doubled <= '0;
          else if (lcnt > ucnt || ucnt == '0)
            median_doubled <= {ltop, 1'b0};
          else median_doubled <= MED_W'(ltop) + MED_W'(utop);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/rmh_checker.sv
// ----------------------------------------------------------------------------
// Running median checker
// Port-level properties of the start/busy/done command interface.
// ----------------------------------------------------------------------------
`default_nettype none
module rmh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [10:0] element_count,
  input wire logic        dropped
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised on accept");
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy still high with result");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    done && dropped |-> element_count != 11'd0) else $error("drop with empty store");
endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .element_count(element_count), .dropped(dropped));
`default_nettype wire

// File: verif/running_median_two_heaps_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Running median two-heap testbench
// Drives signed words through the start/busy handshake, predicts twice the
// running median with a behavioral two-heap model, and checks every strobed
// result in order. The run continues past a full store so that drops occur.
// ----------------------------------------------------------------------------
module running_median_two_heaps_tb;
  localparam int unsigned DEPTH     = 512;
  localparam int          WDOG_MAX  = 4000;
  localparam int          N_RANDOM  = 1400;
  localparam int          N_DIRECT  = 20;

  typedef struct packed {
    logic signed [32:0] med;
    logic [10:0]        cnt;
    logic               drop;
  } median_word_t;

  typedef struct {
    logic signed [31:0] value;
    bit                 typed;
    median_word_t       word;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] sample_value = '0;
  logic               busy;
  logic               done;
  logic signed [32:0] median_doubled;
  logic [10:0]        element_count;
  logic               dropped;

  logic signed [31:0] lo_heap [DEPTH];
  logic signed [31:0] hi_heap [DEPTH];
  int unsigned        lo_cnt;
  int unsigned        hi_cnt;
  median_word_t       median_q [$];
  int                 mismatches = 0;
  int                 idle_pct;
  int                 wdog = 0;
  stim_row_t          rows [N_DIRECT];

  running_median_two_heaps #(.HEAP_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample_value(sample_value),
    .done(done),
    .median_doubled(median_doubled),
    .element_count(element_count),
    .dropped(dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit ranks_over(logic signed [31:0] a, logic signed [31:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_push(bit is_max, logic signed [31:0] v);
    int unsigned        i;
    int unsigned        p;
    logic signed [31:0] t;
    i = is_max ? lo_cnt : hi_cnt;
    if (is_max) begin
      lo_heap[i] = v;
      lo_cnt++;
    end else begin
      hi_heap[i] = v;
      hi_cnt++;
    end
    while (i > 0) begin
      p = (i - 1) / 2;
      if (is_max) begin
        if (!ranks_over(lo_heap[i], lo_heap[p], 1'b1)) break;
        t = lo_heap[p]; lo_heap[p] = lo_heap[i]; lo_heap[i] = t;
      end else begin
        if (!ranks_over(hi_heap[i], hi_heap[p], 1'b0)) break;
        t = hi_heap[p]; hi_heap[p] = hi_heap[i]; hi_heap[i] = t;
      end
      i = p;
    end
  endtask

  task automatic heap_swap_top(bit is_max, logic signed [31:0] v);
    int unsigned        i;
    int unsigned        l;
    int unsigned        best;
    int unsigned        n;
    logic signed [31:0] t;
    i = 0;
    n = is_max ? lo_cnt : hi_cnt;
    if (is_max) lo_heap[0] = v;
    else hi_heap[0] = v;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (is_max) begin
        if (l < n && lo_heap[l] > lo_heap[best]) best = l;
        if (l + 1 < n && lo_heap[l+1] > lo_heap[best]) best = l + 1;
        if (best == i) break;
        t = lo_heap[best]; lo_heap[best] = lo_heap[i]; lo_heap[i] = t;
      end else begin
        if (l < n && hi_heap[l] < hi_heap[best]) best = l;
        if (l + 1 < n && hi_heap[l+1] < hi_heap[best]) best = l + 1;
        if (best == i) break;
        t = hi_heap[best]; hi_heap[best] = hi_heap[i]; hi_heap[i] = t;
      end
      i = best;
    end
  endtask

  // Updates the model heaps with one word and returns the doubled median.
  task automatic median_predict(input logic signed [31:0] x, output median_word_t w);
    logic signed [31:0] top;
    longint             m;
    w.drop = (lo_cnt >= DEPTH) && (hi_cnt >= DEPTH);
    if (!w.drop) begin
      if (lo_cnt == 0 || x <= lo_heap[0]) begin
        if (lo_cnt == hi_cnt + 1) begin
          top = lo_heap[0];
          if (x >= top) heap_push(1'b0, x);
          else begin
            heap_push(1'b0, top);
            heap_swap_top(1'b1, x);
          end
        end else begin
          heap_push(1'b1, x);
        end
      end else if (hi_cnt == lo_cnt) begin
        if (hi_cnt == 0 || x <= hi_heap[0]) heap_push(1'b1, x);
        else begin
          top = hi_heap[0];
          heap_push(1'b1, top);
          heap_swap_top(1'b0, x);
        end
      end else begin
        heap_push(1'b0, x);
      end
    end
    m = 0;
    if (lo_cnt > 0) begin
      if (lo_cnt > hi_cnt || hi_cnt == 0) m = 2 * longint'(lo_heap[0]);
      else m = longint'(lo_heap[0]) + longint'(hi_heap[0]);
    end
    w.med = m[32:0];
    w.cnt = 11'(lo_cnt + hi_cnt);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Presents one word and holds it until the block takes it.
  task automatic send_word(logic signed [31:0] v, bit typed, median_word_t typed_word);
    median_word_t w;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (busy);
    median_predict(v, w);
    median_q.push_back(typed ? typed_word : w);
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1: return 32'($signed($urandom_range(15)) - 8);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (median_q.size() == 0) begin
        report_mismatch("result words outstanding", 1, 0);
      end else begin
        median_word_t w;
        w = median_q.pop_front();
        if (median_doubled !== w.med) report_mismatch("median_doubled", median_doubled, w.med);
        if (element_count !== w.cnt) report_mismatch("element_count", element_count, w.cnt);
        if (dropped !== w.drop) report_mismatch("dropped", dropped, w.drop);
      end
    end
  end

  // Watchdog: cycles with work outstanding but no handshake on either side.
  always @(posedge clk) begin
    if (done || (start && !busy) || (median_q.size() == 0 && !start)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    median_word_t none;
    none = '0;
    lo_cnt = 0;
    hi_cnt = 0;
    idle_pct = 23;
    foreach (rows[i]) rows[i] = '{value: 32'sd0, typed: 1'b0, word: none};
    rows[0] = '{32'sh8000_0000, 1'b1, '{-33'sd4294967296, 11'd1, 1'b0}};
    rows[1] = '{32'sh7FFF_FFFF, 1'b1, '{-33'sd1, 11'd2, 1'b0}};
    rows[2].value = 32'sd0;
    rows[3].value = 32'sd0;
    rows[4].value = -32'sd1;
    rows[5].value = 32'sd1;
    rows[6].value = 32'sh8000_0000;
    rows[7].value = 32'sh7FFF_FFFF;
    rows[8].value = 32'sh7FFF_FFFF;
    rows[9].value = 32'sh7FFF_FFFE;
    rows[10].value = 32'sh8000_0001;
    for (int i = 11; i < N_DIRECT; i++) rows[i].value = 32'(i * 37 - 400);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].value, rows[i].typed, rows[i].word);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) idle_pct = 78;
      else if (n == 2 * N_RANDOM / 3) idle_pct = 0;
      send_word(random_value(), 1'b0, none);
    end
    start <= 1'b0;

    while (median_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: sim.f
design/rmh_pkg.sv
design/rmh_heap.sv
design/running_median_two_heaps.sv
design/rmh_checker.sv
verif/running_median_two_heaps_tb.sv
